@@ hw/rtl/bdq_pkg.sv @@
// Package for the bounded deque: widths, operation and status codes, cell control type.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none
package bdq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned OP_W      = 3;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned OCC_W     = 5;
	localparam int unsigned CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// what every cell does this cycle
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_SHIFT_R,   // take left neighbor (push front)
		CMD_SHIFT_L,   // take right neighbor (pop front)
		CMD_ROTATE,    // take right neighbor, tail takes head (list)
		CMD_PUSH_TAIL  // first free cell takes the pushed word
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      at_tail;  // cell holds the rear entry
		logic      at_next;  // cell is the first free one
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/bdq_if.sv @@
// Valid/ready channel interfaces for the bounded deque request and response.
// Depends on bdq_pkg for field widths.
`default_nettype none
interface bdq_req_if;
	logic                              valid;
	logic                              ready;
	logic [bdq_pkg::OP_W-1:0]          op;
	logic signed [bdq_pkg::DATA_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface bdq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [bdq_pkg::DATA_W-1:0] data;
	logic [bdq_pkg::STAT_W-1:0]        status;
	logic                              last;
	logic [bdq_pkg::OCC_W-1:0]         occupancy;

	modport source (output valid, output data, output status, output last,
		output occupancy, input ready);
	modport sink   (input valid, input data, input status, input last,
		input occupancy, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bdq_cell.sv @@
// One storage cell of the deque chain: holds a word, trades it with its neighbors.
// Depends on bdq_pkg for the control struct and the data width.
`default_nettype none
module bdq_cell (
	input  wire logic                              clk,
	input  wire bdq_pkg::cell_ctl_t                ctl,
	input  wire logic signed [bdq_pkg::DATA_W-1:0] left_d,
	input  wire logic signed [bdq_pkg::DATA_W-1:0] right_d,
	input  wire logic signed [bdq_pkg::DATA_W-1:0] head_d,
	input  wire logic signed [bdq_pkg::DATA_W-1:0] push_d,
	output logic signed [bdq_pkg::DATA_W-1:0]      data_q
);

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			bdq_pkg::CMD_SHIFT_R: data_q <= left_d;
			bdq_pkg::CMD_SHIFT_L: data_q <= right_d;
			bdq_pkg::CMD_ROTATE: begin
				data_q <= ctl.at_tail ? head_d : right_d;
			end
			bdq_pkg::CMD_PUSH_TAIL: begin
				if (ctl.at_next) begin
					data_q <= push_d;
				end
			end
			default: data_q <= data_q;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/bounded_deque_core.sv @@
// Bounded double-ended queue of signed 32-bit words, built as a chain of cells.
// Depends on bdq_pkg, bdq_req_if / bdq_rsp_if and bdq_cell.
//
// Usage:
//  req channel: one transaction per operation (push front/rear, pop front/rear,
//    list). push_value matters only for pushes. Codes 5..7 are consumed silently.
//  rsp channel: pushes and pops give one transaction (pop carries the removed
//    word); a list gives one transaction per held entry, front first, with last
//    set on the final one, or one empty-status transaction on an empty queue.
//  cfg_we/cfg_data: capacity register, to be written only while the block is
//    idle; the user is bound to this, the block itself does not enforce it.
//  Output: the response is registered, valid the cycle after acceptance; a list
//    first enters S_LIST and then registers its first entry.
//  Throughput: pushes and pops go back to back, one per cycle unless stalled,
//    as all cells shift together. A list blocks requests while the chain
//    rotates one place per cycle unless stalled, sending cell 0 out, so after
//    count steps the order is restored. Stall: a held response blocks new
//    requests (one output register), freezing list rotation until it is taken.
//  Reset: count cleared, capacity set to 16, output empty; cell contents are
//    left as is and are never read past count.
`default_nettype none
module bounded_deque_core #(
	parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bdq_req_if.sink                            req,
	bdq_rsp_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [bdq_pkg::CAP_W-1:0]     cfg_data
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	// width wide enough for both count and the capacity register
	localparam int unsigned LW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;
	localparam int unsigned DW = bdq_pkg::DATA_W;

	typedef enum logic {S_IDLE, S_LIST} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              idx_q;
	logic [bdq_pkg::CAP_W-1:0]  cap_q;
	logic                       out_valid_q;
	logic signed [DW-1:0]       out_data_q;
	logic [bdq_pkg::STAT_W-1:0] out_stat_q;
	logic                       out_last_q;
	logic [bdq_pkg::OCC_W-1:0]  out_occ_q;

	logic signed [DW-1:0] cell_q [DEPTH];
	bdq_pkg::cell_ctl_t   ctl    [DEPTH];
	bdq_pkg::cell_cmd_t   cmd;

	logic [LW-1:0]        limit;
	logic                 full;
	logic                 empty;
	logic                 out_free;
	logic                 fire_in;
	logic                 list_step;
	logic                 list_last;
	logic signed [DW-1:0] tail_data;

	// effective limit: capacity clamped to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			limit = LW'(1);
		end else if (LW'(cap_q) > LW'(DEPTH)) begin
			limit = LW'(DEPTH);
		end else begin
			limit = LW'(cap_q);
		end
	end

	assign full      = LW'(count_q) >= limit;
	assign empty     = (count_q == '0);
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign fire_in   = req.valid && req.ready;
	assign list_step = (state_q == S_LIST) && out_free;
	assign list_last = (idx_q == count_q - CW'(1));

	// chain command, broadcast to every cell
	always_comb begin
		cmd = bdq_pkg::CMD_HOLD;
		if (list_step) begin
			cmd = bdq_pkg::CMD_ROTATE;
		end else if (fire_in) begin
			case (req.op)
				bdq_pkg::OP_PUSH_FRONT: if (!full) cmd = bdq_pkg::CMD_SHIFT_R;
				bdq_pkg::OP_PUSH_REAR:  if (!full) cmd = bdq_pkg::CMD_PUSH_TAIL;
				bdq_pkg::OP_POP_FRONT:  if (!empty) cmd = bdq_pkg::CMD_SHIFT_L;
				default:                cmd = bdq_pkg::CMD_HOLD;
			endcase
		end
	end

	// rear entry picked by its one-hot tail flag
	always_comb begin
		tail_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_data = tail_data | (cell_q[i] & {DW{ctl[i].at_tail}});
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DW-1:0] left_d;
		logic signed [DW-1:0] right_d;

		assign ctl[g].cmd     = cmd;
		assign ctl[g].at_tail = (count_q == CW'(g + 1));
		assign ctl[g].at_next = (count_q == CW'(g));

		if (g == 0) begin : g_first
			assign left_d = req.push_value;
		end else begin : g_mid
			assign left_d = cell_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_end
			assign right_d = cell_q[g];
		end else begin : g_inner
			assign right_d = cell_q[g+1];
		end

		bdq_cell u_cell (
			.clk     (clk),
			.ctl     (ctl[g]),
			.left_d  (left_d),
			.right_d (right_d),
			.head_d  (cell_q[0]),
			.push_d  (req.push_value),
			.data_q  (cell_q[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bdq_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// sequencer: count, list walk and the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_stat_q  <= bdq_pkg::ST_OK;
			out_last_q  <= 1'b0;
			out_occ_q   <= '0;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (list_step) begin
				out_valid_q <= 1'b1;
				out_data_q  <= cell_q[0];
				out_stat_q  <= bdq_pkg::ST_OK;
				out_last_q  <= list_last;
				out_occ_q   <= bdq_pkg::OCC_W'(count_q);
				idx_q       <= idx_q + CW'(1);
				if (list_last) begin
					state_q <= S_IDLE;
				end
			end else if (fire_in) begin
				out_data_q <= '0;
				out_last_q <= 1'b1;
				case (req.op)
					bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_REAR: begin
						out_valid_q <= 1'b1;
						if (full) begin
							out_stat_q <= bdq_pkg::ST_FULL;
							out_occ_q  <= bdq_pkg::OCC_W'(count_q);
						end else begin
							out_stat_q <= bdq_pkg::ST_OK;
							out_occ_q  <= bdq_pkg::OCC_W'(count_q + CW'(1));
							count_q    <= count_q + CW'(1);
						end
					end
					bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_REAR: begin
						out_valid_q <= 1'b1;
						if (empty) begin
							out_stat_q <= bdq_pkg::ST_EMPTY;
							out_occ_q  <= '0;
						end else begin
							out_stat_q <= bdq_pkg::ST_OK;
							out_data_q <= (req.op == bdq_pkg::OP_POP_FRONT) ?
								cell_q[0] : tail_data;
							out_occ_q  <= bdq_pkg::OCC_W'(count_q - CW'(1));
							count_q    <= count_q - CW'(1);
						end
					end
					bdq_pkg::OP_LIST: begin
						if (empty) begin
							out_valid_q <= 1'b1;
							out_stat_q  <= bdq_pkg::ST_EMPTY;
							out_occ_q   <= '0;
						end else begin
							state_q <= S_LIST;
							idx_q   <= '0;
						end
					end
					default: begin
						// unused code: consumed, no response
					end
				endcase
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.data      = out_data_q;
	assign rsp.status    = out_stat_q;
	assign rsp.last      = out_last_q;
	assign rsp.occupancy = out_occ_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(count_q) <= LW'(DEPTH))
		else $error("count exceeds depth");

	a_no_req_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |-> !req.ready)
		else $error("request taken during list");

	a_list_ends: assert property (@(posedge clk) disable iff (!arst_n)
		list_step && list_last |=> (state_q == S_IDLE))
		else $error("list did not end on last entry");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire_in && !full && (req.op == bdq_pkg::OP_PUSH_FRONT ||
		req.op == bdq_pkg::OP_PUSH_REAR) |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow count");

	a_list_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |=> $stable(count_q))
		else $error("count changed during list");
`endif

endmodule
`default_nettype wire
